[src/ramr_pkg.sv]
// shared types and command codes for the rational arithmetic unit
package ramr_pkg;

    localparam logic [1:0] CMD_MAKE = 2'd0;
    localparam logic [1:0] CMD_ADD  = 2'd1;
    localparam logic [1:0] CMD_MUL  = 2'd2;

    // control that travels alongside each beat in the divider chain
    typedef struct packed {
        logic valid;
        logic is_den;
    } t_div_ctl;

endpackage

[src/rational_add_multiply_reduce.sv]
// top level: rational make/add/multiply with gcd reduction
//
// Command port: an item is taken at a clock edge with start high and busy low.
// Each item gives one result on o_num_out/o_den_out/o_zero_den_error, shown for
// exactly one cycle with o_valid high; the receiver cannot stall it.
// Unused command, zero denominator: result in the cycle after the beat, and the
// block stays free, so such items may follow back to back.
// Otherwise the item runs: for add and multiply, the numerator and denominator
// products through one shared multiplier (make skips it), then the signed sum
// (a zero sum ends the item with a result of zero over one), the stripping of
// each common factor of two, then binary gcd at one shift or subtract-and-shift
// a cycle (at most about 2*MW steps, MW being 2*OPERAND_WIDTH), and last two
// beats, numerator then denominator, into the division chain and through its
// row of cells. Busy stays high while the item runs. The division chain sets
// the fixed part of the time, the strip and gcd loops the data-dependent part.
// Reset (synchronous, active low) returns the sequencer to idle and empties
// the chain; no result is shown in the cycle after reset.
module rational_add_multiply_reduce #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_cmd,
    input  logic [OPERAND_WIDTH-1:0] i_num_a,
    input  logic [OPERAND_WIDTH-1:0] i_den_a,
    input  logic [OPERAND_WIDTH-1:0] i_num_b,
    input  logic [OPERAND_WIDTH-1:0] i_den_b,
    output logic                     o_valid,
    output logic signed [32:0]       o_num_out,
    output logic [30:0]              o_den_out,
    output logic                     o_zero_den_error
);
    import ramr_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int MW = 2 * OPERAND_WIDTH;
    localparam int KW = $clog2(MW + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SUM, S_STRIP, S_GCD, S_FEED, S_WAIT
    } t_state;

    t_state        r_state, n_state;
    logic [1:0]    r_cmd, n_cmd;
    logic [1:0]    r_ph, n_ph;
    logic [W-1:0]  r_mna, r_mda, r_mnb, r_mdb, n_mna, n_mda, n_mnb, n_mdb;
    logic          r_sna, r_sda, r_snb, r_sdb, n_sna, n_sda, n_snb, n_sdb;
    logic [MW-1:0] r_p0, r_p1, r_n, r_d, r_u, r_v, r_g, r_nq;
    logic [MW-1:0] n_p0, n_p1, n_n, n_d, n_u, n_v, n_g, n_nq;
    logic          r_neg, n_neg;
    logic [KW-1:0] r_k, n_k;
    logic          n_valid;
    logic [32:0]   n_num_out;
    logic [30:0]   n_den_out;
    logic          n_err;

    logic          accept;
    logic [W-1:0]  mag_na, mag_da, mag_nb, mag_db;
    logic [W-1:0]  mul_a, mul_b;
    logic [MW-1:0] prod;
    logic          sa, sb;
    logic [MW-1:0] sum_mag;
    logic          sum_sign;
    logic          den_sign;
    logic signed [MW:0] snum;

    t_div_ctl      feed_ctl, out_ctl;
    logic [MW-1:0] feed_dvd, out_q;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    function automatic logic [W-1:0] magnitude(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    always_comb begin
        mag_na = magnitude(i_num_a);
        mag_da = magnitude(i_den_a);
        mag_nb = magnitude(i_num_b);
        mag_db = magnitude(i_den_b);

        // one shared multiplier, operands picked by phase
        case (r_ph)
            2'd0:    begin mul_a = r_mna; mul_b = (r_cmd == CMD_ADD) ? r_mdb : r_mnb; end
            2'd1:    begin mul_a = r_mda; mul_b = r_mnb; end
            default: begin mul_a = r_mda; mul_b = r_mdb; end
        endcase
        prod = {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};

        // signed-magnitude numerator
        if (r_cmd == CMD_ADD) begin
            sa = r_sna ^ r_sdb;
            sb = r_sda ^ r_snb;
            if (sa == sb) begin
                sum_mag = r_p0 + r_p1; sum_sign = sa;
            end else if (r_p0 >= r_p1) begin
                sum_mag = r_p0 - r_p1; sum_sign = sa;
            end else begin
                sum_mag = r_p1 - r_p0; sum_sign = sb;
            end
        end else begin
            sa = r_sna;
            sb = r_snb;
            sum_mag  = r_p0;
            sum_sign = (r_cmd == CMD_MUL) ? (sa ^ sb) : sa;
        end
        den_sign = (r_cmd == CMD_MAKE) ? r_sda : (r_sda ^ r_sdb);

        snum = r_neg ? -$signed({1'b0, r_nq}) : $signed({1'b0, r_nq});
    end

    always_comb begin
        n_state = r_state;
        n_cmd = r_cmd;  n_ph = r_ph;
        n_mna = r_mna;  n_mda = r_mda;  n_mnb = r_mnb;  n_mdb = r_mdb;
        n_sna = r_sna;  n_sda = r_sda;  n_snb = r_snb;  n_sdb = r_sdb;
        n_p0 = r_p0;  n_p1 = r_p1;  n_n = r_n;  n_d = r_d;
        n_u = r_u;  n_v = r_v;  n_g = r_g;  n_nq = r_nq;
        n_neg = r_neg;  n_k = r_k;
        n_valid = 1'b0;
        n_num_out = o_num_out;
        n_den_out = o_den_out;
        n_err = o_zero_den_error;
        feed_ctl = '0;
        feed_dvd = r_n;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd = i_cmd;
                    n_mna = mag_na; n_mda = mag_da; n_mnb = mag_nb; n_mdb = mag_db;
                    n_sna = i_num_a[W-1]; n_sda = i_den_a[W-1];
                    n_snb = i_num_b[W-1]; n_sdb = i_den_b[W-1];
                    n_ph = 2'd0;
                    if (i_cmd != CMD_MAKE && i_cmd != CMD_ADD && i_cmd != CMD_MUL) begin
                        n_valid = 1'b1; n_num_out = '0; n_den_out = 31'd1; n_err = 1'b0;
                    end else if (mag_da == '0 || (i_cmd != CMD_MAKE && mag_db == '0)) begin
                        n_valid = 1'b1; n_num_out = '0; n_den_out = 31'd1; n_err = 1'b1;
                    end else if (i_cmd == CMD_MAKE) begin
                        n_p0 = {{W{1'b0}}, mag_na};
                        n_d  = {{W{1'b0}}, mag_da};
                        n_state = S_SUM;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                case (r_ph)
                    2'd0:    n_p0 = prod;
                    2'd1:    n_p1 = prod;
                    default: n_d  = prod;
                endcase
                n_ph = r_ph + 2'd1;
                if (r_ph == 2'd2) n_state = S_SUM;
            end
            S_SUM: begin
                if (sum_mag == '0) begin
                    n_valid = 1'b1; n_num_out = '0; n_den_out = 31'd1; n_err = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_n = sum_mag;
                    n_u = sum_mag;
                    n_v = r_d;
                    n_neg = sum_sign ^ den_sign;
                    n_k = '0;
                    n_state = S_STRIP;
                end
            end
            S_STRIP: begin
                // common factors of two, counted and put back at the end
                if (!r_u[0] && !r_v[0]) begin
                    n_u = r_u >> 1;
                    n_v = r_v >> 1;
                    n_k = r_k + 1'b1;
                end else begin
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                if (r_u == '0) begin
                    n_g = r_v << r_k;
                    n_ph = 2'd0;
                    n_state = S_FEED;
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (r_u >= r_v) begin
                    n_u = (r_u - r_v) >> 1;
                end else begin
                    n_v = (r_v - r_u) >> 1;
                end
            end
            S_FEED: begin
                feed_ctl.valid  = 1'b1;
                feed_ctl.is_den = r_ph[0];
                feed_dvd = r_ph[0] ? r_d : r_n;
                n_ph = r_ph + 2'd1;
                if (r_ph[0]) n_state = S_WAIT;
            end
            S_WAIT: begin
                if (out_ctl.valid && !out_ctl.is_den) begin
                    n_nq = out_q;
                end
                if (out_ctl.valid && out_ctl.is_den) begin
                    n_valid = 1'b1;
                    n_num_out = 33'(snum);
                    n_den_out = 31'(out_q);
                    n_err = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            o_valid <= n_valid;
        end
        r_cmd <= n_cmd;
        r_mna <= n_mna; r_mda <= n_mda; r_mnb <= n_mnb; r_mdb <= n_mdb;
        r_sna <= n_sna; r_sda <= n_sda; r_snb <= n_snb; r_sdb <= n_sdb;
        r_p0 <= n_p0; r_p1 <= n_p1; r_n <= n_n; r_d <= n_d;
        r_u <= n_u; r_v <= n_v; r_g <= n_g; r_nq <= n_nq;
        r_neg <= n_neg; r_k <= n_k;
        o_num_out <= n_num_out;
        o_den_out <= n_den_out;
        o_zero_den_error <= n_err;
    end

    ramr_chain #(.MW(MW)) u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (feed_ctl),
        .i_dividend(feed_dvd),
        .i_divisor (r_g),
        .o_ctl     (out_ctl),
        .o_quotient(out_q)
    );

    // a beat leaving the chain always finds the sequencer waiting for it
    a_chain_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ctl.valid |-> r_state == S_WAIT)
        else $error("division beat left chain outside wait state");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_den_error |-> o_num_out == '0 && o_den_out == 31'd1)
        else $error("error result is not zero over one");

    a_trivial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_den_a == '0) &&
        (i_cmd == CMD_MAKE || i_cmd == CMD_ADD || i_cmd == CMD_MUL)
        |=> o_valid && o_zero_den_error)
        else $error("zero denominator not flagged next cycle");

    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FEED |-> r_g != '0)
        else $error("divisor fed to chain is zero");

endmodule

[src/ramr_cell.sv]
// one restoring-division step: takes one quotient bit, hands the beat on
module ramr_cell #(
    parameter int MW = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ramr_pkg::t_div_ctl  i_ctl,
    input  logic [MW-1:0]       i_rem,
    input  logic [MW-1:0]       i_dq,
    input  logic [MW-1:0]       i_dvs,
    output ramr_pkg::t_div_ctl  o_ctl,
    output logic [MW-1:0]       o_rem,
    output logic [MW-1:0]       o_dq,
    output logic [MW-1:0]       o_dvs
);
    import ramr_pkg::*;

    logic [MW:0]   trial;
    logic [MW:0]   diff;
    logic          ge;
    logic [MW-1:0] n_rem;
    logic [MW-1:0] n_dq;

    always_comb begin
        trial = {i_rem, i_dq[MW-1]};
        diff  = trial - {1'b0, i_dvs};
        ge    = !diff[MW];
        n_rem = ge ? diff[MW-1:0] : trial[MW-1:0];
        // dividend bits leave at the top, quotient bits enter at the bottom
        n_dq  = {i_dq[MW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else begin
            o_ctl <= i_ctl;
        end
        o_rem <= n_rem;
        o_dq  <= n_dq;
        o_dvs <= i_dvs;
    end

endmodule

[src/ramr_chain.sv]
// row of division cells: a beat enters each cycle, its quotient leaves from the last cell
module ramr_chain #(
    parameter int MW = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ramr_pkg::t_div_ctl  i_ctl,
    input  logic [MW-1:0]       i_dividend,
    input  logic [MW-1:0]       i_divisor,
    output ramr_pkg::t_div_ctl  o_ctl,
    output logic [MW-1:0]       o_quotient
);
    import ramr_pkg::*;

    t_div_ctl      ctl [0:MW];
    logic [MW-1:0] rem [0:MW];
    logic [MW-1:0] dq  [0:MW];
    logic [MW-1:0] dvs [0:MW];

    assign ctl[0] = i_ctl;
    assign rem[0] = '0;
    assign dq[0]  = i_dividend;
    assign dvs[0] = i_divisor;

    for (genvar g = 0; g < MW; g++) begin : g_cell
        ramr_cell #(.MW(MW)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (ctl[g]),
            .i_rem  (rem[g]),
            .i_dq   (dq[g]),
            .i_dvs  (dvs[g]),
            .o_ctl  (ctl[g+1]),
            .o_rem  (rem[g+1]),
            .o_dq   (dq[g+1]),
            .o_dvs  (dvs[g+1])
        );
    end

    assign o_ctl      = ctl[MW];
    assign o_quotient = dq[MW];

endmodule
